FILE: src/dmpd_pkg.sv
// Shared types and codes of the dual motor PWM direction driver.
package dmpd_pkg;

	// Command codes carried in the cmd field.
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_SPEED = 2'd1;
	localparam logic [1:0] CMD_BRAKE = 2'd2;

	// Per-motor drive modes.
	localparam logic [1:0] MODE_COAST = 2'd0;
	localparam logic [1:0] MODE_FWD   = 2'd1;
	localparam logic [1:0] MODE_REV   = 2'd2;
	localparam logic [1:0] MODE_BRAKE = 2'd3;

	// Width of the signed speed field and of its magnitude.
	localparam int SPEED_BITS = 16;
	localparam int MAG_BITS   = SPEED_BITS + 1;

	// Packed widths of the stream words.
	localparam int IN_DATA_BITS  = 24;
	localparam int OUT_DATA_BITS = 8;

	// One input word after unpacking.
	typedef struct packed {
		logic [1:0]                   cmd;
		logic                         motor;
		logic signed [SPEED_BITS-1:0] speed;
	} item_t;

	// Control handed from the input stage to the motor channels.
	typedef struct packed {
		logic  upd;
		item_t item;
	} upd_t;

endpackage

FILE: src/dmpd_in_stage.sv
// Input register stage: holds one accepted word until the result stage takes it.
module dmpd_in_stage (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [dmpd_pkg::IN_DATA_BITS-1:0]   in_data,
	input  logic                                adv,
	output logic                                valid_s1,
	output dmpd_pkg::item_t                     item_s1
);

	// Free when empty or when the held word moves on this cycle.
	assign in_ready = !valid_s1 || adv;

	// Valid flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload: cmd in bits 1:0, motor in bit 2, speed in bits 18:3.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.cmd   <= in_data[1:0];
			item_s1.motor <= in_data[2];
			item_s1.speed <= in_data[dmpd_pkg::SPEED_BITS+2:3];
		end
	end

endmodule

FILE: src/dmpd_motor.sv
// One motor channel: mode and duty state, speed saturation and pin levels.
module dmpd_motor #(
	parameter int   COUNT_BITS = 8,
	parameter logic MOTOR_ID   = 1'b0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dmpd_pkg::upd_t        ctl,
	input  logic [COUNT_BITS-1:0] count_n,
	output logic                  fwd,
	output logic                  rev
);

	localparam logic [dmpd_pkg::MAG_BITS-1:0] DUTY_MAX =
		dmpd_pkg::MAG_BITS'((1 << COUNT_BITS) - 1);

	logic [1:0]                      mode_q, mode_n;
	logic [COUNT_BITS-1:0]           duty_q, duty_n;
	logic [dmpd_pkg::MAG_BITS-1:0]   mag;
	logic [COUNT_BITS-1:0]           duty_sat;
	logic                            hit;
	logic                            on;

	// Magnitude of the signed speed, saturated to the counter range.
	always_comb begin
		if (ctl.item.speed[dmpd_pkg::SPEED_BITS-1]) begin
			mag = {1'b1, {dmpd_pkg::SPEED_BITS{1'b0}}} -
				{1'b0, ctl.item.speed};
		end else begin
			mag = {1'b0, ctl.item.speed};
		end
		duty_sat = (mag > DUTY_MAX) ? DUTY_MAX[COUNT_BITS-1:0] : mag[COUNT_BITS-1:0];
	end

	assign hit = ctl.upd && (ctl.item.motor == MOTOR_ID);

	// Next mode and duty; coast and brake keep the stored duty.
	always_comb begin
		mode_n = mode_q;
		duty_n = duty_q;
		if (hit) begin
			case (ctl.item.cmd)
				dmpd_pkg::CMD_SPEED: begin
					if (ctl.item.speed == '0) begin
						mode_n = dmpd_pkg::MODE_COAST;
					end else begin
						mode_n = ctl.item.speed[dmpd_pkg::SPEED_BITS-1] ?
							dmpd_pkg::MODE_REV : dmpd_pkg::MODE_FWD;
						duty_n = duty_sat;
					end
				end
				dmpd_pkg::CMD_BRAKE: begin
					mode_n = dmpd_pkg::MODE_BRAKE;
				end
				default: begin
					mode_n = mode_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= dmpd_pkg::MODE_COAST;
			duty_q <= '0;
		end else begin
			mode_q <= mode_n;
			duty_q <= duty_n;
		end
	end

	// Pin levels after this word, from the updated state and counter.
	assign on = (count_n < duty_n);

	always_comb begin
		case (mode_n)
			dmpd_pkg::MODE_FWD: begin
				fwd = on;
				rev = 1'b0;
			end
			dmpd_pkg::MODE_REV: begin
				fwd = 1'b0;
				rev = on;
			end
			dmpd_pkg::MODE_BRAKE: begin
				fwd = 1'b1;
				rev = 1'b1;
			end
			default: begin
				fwd = 1'b0;
				rev = 1'b0;
			end
		endcase
	end

endmodule

FILE: src/dual_motor_pwm_direction_driver_top.sv
// Top level of the dual motor PWM direction driver.
//
// Input stream (s_axis): one word per command. A tick advances the shared
// PWM counter, a set-speed word gives motor A or B a signed speed (sign picks
// the pin, magnitude saturates to the counter range), a brake word drives
// both pins of that motor high.
// Output stream (m_axis): one word per input word, the four bridge input
// levels in1..in4 as they stand after that command.
// An accepted word passes through one input register, then the state update
// and pin compare feeding the result register, which offers it on m_axis.
// Throughput is one word per clock while the receiver takes results; the
// input register and the result register each hold a word, so a new word is
// taken while a finished result still waits for the receiver.
// When the receiver stalls, the result holds and the input register fills;
// s_axis_tready drops only when both hold a word.
// Reset clears the counter, sets both motors to coast with zero duty and
// empties both registers.
module dual_motor_pwm_direction_driver_top #(
	parameter int COUNT_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// Fields from bit 0: cmd[1:0], motor[2], speed[18:3], zero pad [23:19].
	input  logic [dmpd_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// Fields from bit 0: in1[0], in2[1], in3[2], in4[3], zero pad [7:4].
	output logic [dmpd_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata
);

	logic                   valid_s1;
	dmpd_pkg::item_t        item_s1;
	logic                   adv;
	dmpd_pkg::upd_t         ctl;
	logic [COUNT_BITS-1:0]  count_q, count_n;
	logic                   a_fwd, a_rev, b_fwd, b_rev;
	logic                   valid_s2;
	logic [3:0]             pins_s2;

	// Move a word into the result register when it is empty or being read.
	assign adv = valid_s1 && (!valid_s2 || m_axis_tready);

	assign ctl.upd  = adv;
	assign ctl.item = item_s1;

	dmpd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// Shared PWM counter, advanced by each tick word as it moves on.
	assign count_n = (adv && (item_s1.cmd == dmpd_pkg::CMD_TICK)) ?
		count_q + COUNT_BITS'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_n;
		end
	end

	dmpd_motor #(.COUNT_BITS(COUNT_BITS), .MOTOR_ID(1'b0)) u_motor_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.count_n (count_n),
		.fwd     (a_fwd),
		.rev     (a_rev)
	);

	dmpd_motor #(.COUNT_BITS(COUNT_BITS), .MOTOR_ID(1'b1)) u_motor_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.count_n (count_n),
		.fwd     (b_fwd),
		.rev     (b_rev)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pins_s2 <= {b_rev, b_fwd, a_rev, a_fwd};
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(dmpd_pkg::OUT_DATA_BITS - 4){1'b0}}, pins_s2};

endmodule

FILE: src/dmpd_checker.sv
// Port-level checks of the driver, bound to its top level.
module dmpd_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [dmpd_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

	// A stalled result stays offered and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result word changed or vanished");

	// The pad bits of the result word are always zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[dmpd_pkg::OUT_DATA_BITS-1:4] == '0))
		else $error("result pad bits set");

	// With the result side free, the input side is never blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tready || !m_axis_tvalid) |-> s_axis_tready)
		else $error("input blocked while result side is free");

	// A word taken into an empty output path shows a result once it has passed the input and result registers.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> ##1 m_axis_tvalid)
		else $error("result missing two cycles after input");

endmodule

bind dual_motor_pwm_direction_driver_top dmpd_checker u_dmpd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
